// ===== rtl/drcgra_pkg.sv =====
package drcgra_pkg;

	// input operations
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_PREV  = 2'd1,
		OP_NODE  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [1:0] CFG_FRAME_SIZE   = 2'd0;
	localparam logic [1:0] CFG_STEP_LOG2    = 2'd1;
	localparam logic [1:0] CFG_CHANNEL_GAIN = 2'd2;

	localparam logic signed [31:0] UNITY_E7 = 32'sd16777216;
	localparam logic signed [31:0] UNITY_E8 = 32'sd8388608;
	localparam logic [3:0] MAX_STEP_LOG2 = 4'd8;

	// index and run counters cover any in-frame segment
	localparam int IDX_W = 17;
	// segment arithmetic width
	localparam int SEG_W = 20;
	// ramp numerator and quotient width
	localparam int NUM_W = 42;
	// shared multiplier operand width
	localparam int MUL_W = 33;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_GCHK,
		ST_GML,
		ST_GMR,
		ST_GCAP,
		ST_PLAN,
		ST_PLAN2,
		ST_DIV,
		ST_ALO,
		ST_AHI,
		ST_ASUM,
		ST_SRD,
		ST_SMUL,
		ST_SWR,
		ST_FIN
	} state_t;

endpackage

// ===== rtl/drcgra_mul.sv =====
module drcgra_mul (
	input  logic                                   clk,
	input  logic signed [drcgra_pkg::MUL_W-1:0]   a,
	input  logic signed [drcgra_pkg::MUL_W-1:0]   b,
	output logic signed [2*drcgra_pkg::MUL_W-1:0] p_q
);

	// registered signed product
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ===== rtl/drcgra_div.sv =====
module drcgra_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [drcgra_pkg::NUM_W-1:0] num,
	input  logic [14:0]                          den,
	output logic                                 done,
	output logic signed [drcgra_pkg::NUM_W-1:0] quo
);

	localparam int MAG_W = drcgra_pkg::NUM_W - 1;

	logic [5:0]       cnt_q;
	logic             run_q;
	logic             done_q;
	logic             neg_q;
	logic [14:0]      den_q;
	logic [14:0]      rem_q;
	logic [MAG_W-1:0] mag_q;
	logic [15:0]      shifted;
	logic             fits;
	logic [drcgra_pkg::NUM_W-1:0] num_abs;

	assign num_abs = num[drcgra_pkg::NUM_W-1] ? -num : num;
	assign shifted = {rem_q, mag_q[MAG_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	// restoring division, one quotient bit a cycle, truncates toward zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(MAG_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[drcgra_pkg::NUM_W-1];
			den_q <= den;
			rem_q <= '0;
			mag_q <= num_abs[MAG_W-1:0];
		end else if (run_q) begin
			rem_q <= fits ? 15'(shifted - {1'b0, den_q}) : shifted[14:0];
			mag_q <= {mag_q[MAG_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

// ===== rtl/drc_node_gain_ramp_apply.sv =====
// A sample write or set-previous-node completes on acceptance; a read registers the store
// word, sets out_valid from ST_RD and holds further reads until that word is taken.
// A gain node that ramps scales both gains, plans and divides, then rewrites each sample
// (read, shared multiply, write back); skipped nodes leave before the divider.
// Throughput: one item at a time, input stalled meanwhile. Async active-low reset restores
// unity gains, zero times and default registers; the sample store is not cleared.
module drc_node_gain_ramp_apply #(
	parameter int STORE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [9:0]         sample_index,
	input  logic signed [31:0] sample_value,
	input  logic signed [15:0] node_time,
	input  logic signed [31:0] node_gain,
	input  logic signed [15:0] time_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] sample_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int IW = drcgra_pkg::IDX_W;
	localparam int SW = drcgra_pkg::SEG_W;
	localparam int NW = drcgra_pkg::NUM_W;
	localparam int MW = drcgra_pkg::MUL_W;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// shared headroom of both gains, capped at 8
	function automatic logic [3:0] headroom(input logic [31:0] v);
		logic [3:0] h;
		h = 4'd8;
		for (int m = 7; m >= 0; m--) begin
			if (v[30-m]) h = 4'(m);
		end
		if (v[31]) h = 4'd0;
		return h;
	endfunction

	drcgra_pkg::state_t state_q, state_d;

	// registers
	logic [10:0]        frame_size_q;
	logic [3:0]         step_log2_q;
	logic signed [31:0] channel_gain_q;

	// node state
	logic signed [15:0] prev_time_q, seg_off_q;
	logic signed [31:0] prev_gain_q, prev_cgain_q;

	// per-node working registers
	logic signed [15:0] node_time_q, t_q, tp_q, d_q;
	logic signed [31:0] node_gain_q, gl_q, gr_q;
	logic signed [SW-1:0] start_q, stop_q, base_q;
	logic [3:0]         h_q, k_q;
	logic [8:0]         soff_q;
	logic [IW-1:0]      nbuf_q, runs_q, n_q, run_q, idx_q;
	logic signed [NW-1:0] inc_q;
	logic signed [63:0] a_q, plo_q;

	// store and read path
	logic signed [31:0] mem [STORE_DEPTH];
	logic               mem_wr_en, mem_rd_en;
	logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
	logic signed [31:0] mem_wr_data;
	logic signed [31:0] rd_data_q;
	logic               rd_oob_q;
	logic               out_valid_q;
	logic signed [31:0] out_data_q;

	// shared units
	logic signed [MW-1:0]   mul_a, mul_b;
	logic signed [2*MW-1:0] mul_p;
	logic                   div_start, div_done;
	logic signed [NW-1:0]   div_quo, div_num;

	// combinational helpers
	logic               accept;
	logic [IW-1:0]      in_idx;
	logic               in_idx_ok;
	logic signed [15:0] d_now;
	logic signed [SW-1:0] tp_w, t_w, fs1_w, neg_tp, stop_now, start_now;
	logic [3:0]         k_now;
	logic [8:0]         step_w, mask_w, mod_w, soff_now;
	logic signed [SW-1:0] nsum, span_w;
	logic signed [32:0] gdiff;
	logic signed [63:0] prod64, istep, gl_sh;
	logic signed [31:0] a_sat, ps;
	logic signed [63:0] ps_sh;
	logic               unity_pair;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != drcgra_pkg::ST_IDLE)
		|| (operation == drcgra_pkg::OP_READ && out_valid_q);
	assign cfg_ready = 1'b1;
	assign out_valid  = out_valid_q;
	assign sample_out = out_data_q;

	assign in_idx    = IW'(sample_index);
	assign in_idx_ok = in_idx < IW'(STORE_DEPTH);

	// segment geometry
	assign d_now     = t_q - tp_q;
	assign tp_w      = SW'(tp_q);
	assign t_w       = SW'(t_q);
	assign fs1_w     = $signed(SW'({1'b0, frame_size_q})) - SW'(1);
	assign neg_tp    = -tp_w;
	assign start_now = (neg_tp > SW'(1)) ? neg_tp : SW'(1);
	assign stop_now  = ((t_w < fs1_w) ? t_w : fs1_w) - tp_w + SW'(1);

	assign k_now    = (step_log2_q > drcgra_pkg::MAX_STEP_LOG2) ? drcgra_pkg::MAX_STEP_LOG2
		: step_log2_q;
	assign step_w   = 9'd1 << k_now;
	assign mask_w   = step_w - 9'd1;
	assign mod_w    = base_q[8:0] & mask_w;
	assign soff_now = (mod_w != 9'd0) ? step_w - mod_w : 9'd0;
	assign nsum     = base_q + $signed(SW'(soff_q));
	assign span_w   = stop_q - start_q - $signed(SW'(soff_q)) + $signed(SW'(10'd1 << k_q))
		- SW'(1);
	assign unity_pair = (gl_q == drcgra_pkg::UNITY_E7) && (gr_q == drcgra_pkg::UNITY_E7);

	assign gdiff   = {gr_q[31], gr_q} - {gl_q[31], gl_q};
	assign div_num = NW'(gdiff) <<< h_q;

	assign prod64 = mul_p[63:0];
	assign istep  = 64'(inc_q) <<< k_q;
	assign gl_sh  = 64'(gl_q) <<< h_q;
	assign a_sat  = sat32(a_q);
	assign ps     = prod64[63:32];
	assign ps_sh  = 64'(ps) <<< (4'd8 - h_q);

	drcgra_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	drcgra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (d_q[14:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer: next state, store controls, multiplier operands, divider start
	always_comb begin
		state_d     = state_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = in_idx[AW-1:0];
		mem_wr_data = sample_value;
		mem_rd_en   = 1'b0;
		mem_rd_addr = in_idx[AW-1:0];
		mul_a       = '0;
		mul_b       = '0;
		div_start   = 1'b0;
		case (state_q)
			drcgra_pkg::ST_IDLE: begin
				if (accept) begin
					case (operation)
						drcgra_pkg::OP_WRITE: mem_wr_en = in_idx_ok;
						drcgra_pkg::OP_NODE:  state_d = drcgra_pkg::ST_GCHK;
						drcgra_pkg::OP_READ: begin
							mem_rd_en = in_idx_ok;
							state_d   = drcgra_pkg::ST_RD;
						end
						default: ;
					endcase
				end
			end
			drcgra_pkg::ST_RD: state_d = drcgra_pkg::ST_IDLE;
			drcgra_pkg::ST_GCHK: begin
				if (d_now < 0) state_d = drcgra_pkg::ST_IDLE;
				else if (tp_w >= fs1_w || t_q < 0) state_d = drcgra_pkg::ST_FIN;
				else state_d = drcgra_pkg::ST_GML;
			end
			drcgra_pkg::ST_GML: begin
				mul_a   = MW'(prev_gain_q);
				mul_b   = MW'(prev_cgain_q);
				state_d = drcgra_pkg::ST_GMR;
			end
			drcgra_pkg::ST_GMR: begin
				mul_a   = MW'(node_gain_q);
				mul_b   = (start_q == 1) ? MW'(channel_gain_q) : MW'(prev_cgain_q);
				state_d = drcgra_pkg::ST_GCAP;
			end
			drcgra_pkg::ST_GCAP: state_d = drcgra_pkg::ST_PLAN;
			drcgra_pkg::ST_PLAN: begin
				if (d_q == 0 || unity_pair) state_d = drcgra_pkg::ST_FIN;
				else state_d = drcgra_pkg::ST_PLAN2;
			end
			drcgra_pkg::ST_PLAN2: begin
				if (span_w <= 0 || (span_w >>> k_q) == 0) begin
					state_d = drcgra_pkg::ST_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = drcgra_pkg::ST_DIV;
				end
			end
			drcgra_pkg::ST_DIV: begin
				if (div_done) state_d = drcgra_pkg::ST_ALO;
			end
			drcgra_pkg::ST_ALO: begin
				mul_a   = MW'({1'b0, inc_q[23:0]});
				mul_b   = MW'({1'b0, n_q});
				state_d = drcgra_pkg::ST_AHI;
			end
			drcgra_pkg::ST_AHI: begin
				mul_a   = MW'($signed(inc_q[NW-1:24]));
				mul_b   = MW'({1'b0, n_q});
				state_d = drcgra_pkg::ST_ASUM;
			end
			drcgra_pkg::ST_ASUM: state_d = drcgra_pkg::ST_SRD;
			drcgra_pkg::ST_SRD: begin
				mem_rd_addr = idx_q[AW-1:0];
				if (run_q == runs_q) begin
					state_d = drcgra_pkg::ST_FIN;
				end else if (idx_q < IW'(STORE_DEPTH)) begin
					mem_rd_en = 1'b1;
					state_d   = drcgra_pkg::ST_SMUL;
				end
			end
			drcgra_pkg::ST_SMUL: begin
				mul_a   = MW'(rd_data_q);
				mul_b   = MW'(a_sat);
				state_d = drcgra_pkg::ST_SWR;
			end
			drcgra_pkg::ST_SWR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = idx_q[AW-1:0];
				mem_wr_data = sat32(ps_sh);
				state_d     = drcgra_pkg::ST_SRD;
			end
			drcgra_pkg::ST_FIN: state_d = drcgra_pkg::ST_IDLE;
			default: state_d = drcgra_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= drcgra_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// sample store
	always_ff @(posedge clk) begin
		if (mem_wr_en) mem[mem_wr_addr] <= mem_wr_data;
		if (mem_rd_en) rd_data_q <= mem[mem_rd_addr];
	end

	// configuration, node state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q   <= 11'd1024;
			step_log2_q    <= 4'd0;
			channel_gain_q <= drcgra_pkg::UNITY_E8;
			prev_time_q    <= '0;
			prev_gain_q    <= drcgra_pkg::UNITY_E7;
			seg_off_q      <= '0;
			prev_cgain_q   <= drcgra_pkg::UNITY_E8;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					drcgra_pkg::CFG_FRAME_SIZE:   frame_size_q <= cfg_data[10:0];
					drcgra_pkg::CFG_STEP_LOG2:    step_log2_q <= cfg_data[3:0];
					drcgra_pkg::CFG_CHANNEL_GAIN: channel_gain_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				drcgra_pkg::ST_IDLE: begin
					if (accept && operation == drcgra_pkg::OP_PREV) begin
						prev_time_q <= node_time;
						prev_gain_q <= node_gain;
						seg_off_q   <= time_offset;
					end
				end
				drcgra_pkg::ST_RD: out_valid_q <= 1'b1;
				drcgra_pkg::ST_GMR: begin
					if (start_q == 1) prev_cgain_q <= channel_gain_q;
				end
				drcgra_pkg::ST_FIN: begin
					prev_time_q <= node_time_q;
					prev_gain_q <= node_gain_q;
				end
				default: ;
			endcase
		end
	end

	// per-node datapath and read output word
	always_ff @(posedge clk) begin
		case (state_q)
			drcgra_pkg::ST_IDLE: begin
				node_time_q <= node_time;
				node_gain_q <= node_gain;
				t_q         <= node_time + seg_off_q;
				tp_q        <= prev_time_q + seg_off_q;
				rd_oob_q    <= !in_idx_ok;
			end
			drcgra_pkg::ST_RD: out_data_q <= rd_oob_q ? 32'sd0 : rd_data_q;
			drcgra_pkg::ST_GCHK: begin
				d_q     <= d_now;
				start_q <= start_now;
				stop_q  <= stop_now;
				base_q  <= start_now + tp_w;
			end
			drcgra_pkg::ST_GMR: gl_q <= sat32(prod64 >>> 23);
			drcgra_pkg::ST_GCAP: gr_q <= sat32(prod64 >>> 23);
			drcgra_pkg::ST_PLAN: begin
				k_q    <= k_now;
				soff_q <= soff_now;
				h_q    <= headroom(gl_q | gr_q);
			end
			drcgra_pkg::ST_PLAN2: begin
				nbuf_q <= IW'(nsum >>> k_q);
				runs_q <= IW'(span_w >>> k_q);
				n_q    <= IW'(start_q + $signed(SW'(soff_q)));
			end
			drcgra_pkg::ST_DIV: begin
				if (div_done) inc_q <= div_quo;
			end
			drcgra_pkg::ST_AHI: plo_q <= prod64;
			drcgra_pkg::ST_ASUM: begin
				a_q   <= plo_q + (prod64 <<< 24) + gl_sh;
				run_q <= '0;
				idx_q <= nbuf_q;
			end
			drcgra_pkg::ST_SRD: begin
				if (run_q != runs_q && !(idx_q < IW'(STORE_DEPTH))) begin
					a_q   <= a_q + istep;
					run_q <= run_q + 1'b1;
					idx_q <= idx_q + 1'b1;
				end
			end
			drcgra_pkg::ST_SWR: begin
				a_q   <= a_q + istep;
				run_q <= run_q + 1'b1;
				idx_q <= idx_q + 1'b1;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == drcgra_pkg::ST_SWR |-> run_q < runs_q)
		else $error("sample rewrite beyond segment run count");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == drcgra_pkg::ST_DIV)
		else $error("divider finished outside its wait state");

	a_read_free: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == drcgra_pkg::OP_READ) |-> !out_valid_q)
		else $error("read accepted while output word pending");

	a_read_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == drcgra_pkg::ST_RD |=> out_valid_q)
		else $error("read did not produce an output word");
`endif

endmodule

// ===== test/tb.sv =====
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 1024;
	localparam int IDLE_LIMIT = 50000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         operation = drcgra_pkg::OP_WRITE;
	logic [9:0]         sample_index = '0;
	logic signed [31:0] sample_value = '0;
	logic signed [15:0] node_time = '0;
	logic signed [31:0] node_gain = '0;
	logic signed [15:0] time_offset = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] sample_out;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = drcgra_pkg::CFG_FRAME_SIZE;
	logic [31:0]        cfg_data = '0;

	drc_node_gain_ramp_apply #(.STORE_DEPTH(DEPTH)) uut (.*);

	always #5 clk = ~clk;

	// gain model state
	int          mdl_store [DEPTH];
	bit          mdl_wr [DEPTH];
	int          mdl_ptime, mdl_pgain, mdl_seg_off, mdl_pchan;
	int unsigned mdl_fsize, mdl_step;
	int          mdl_chan;

	// expected read words, oldest first
	int    read_words [$];
	int    fail_cnt, read_cnt, node_cnt, ramp_cnt, item_cnt;
	bit    quiet, hold_req;

	typedef struct {
		drcgra_pkg::op_t op;
		int      idx;
		int      val;
		int      nt;
		int      ng;
		int      toff;
		bit      typed;
		int      want;
	} row_t;
	row_t steps [$];

	function automatic int wrap16(longint v);
		return int'(shortint'(v));
	endfunction

	function automatic int sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic int lzc(int v);
		int n;
		logic [31:0] u;
		u = v;
		n = 0;
		if (u == 0) return 32;
		while (!u[31]) begin
			u = u << 1;
			n++;
		end
		return n;
	endfunction

	function automatic int scale_gain(int g, int c);
		return sat32((longint'(g) * longint'(c)) >>> 23);
	endfunction

	// ramp between gl and gr over the in-frame positions, decimated by the hop
	function automatic void apply_ramp(int tp, int d, int start, int stop, int gl, int gr);
		int k, hop, md, soff, nbuf, span, runs, h, n, idx, g;
		longint inc, istep, acc, p;
		k = mdl_step > 8 ? 8 : mdl_step;
		hop = 1 << k;
		if (d <= 0) return;
		if (gl == drcgra_pkg::UNITY_E7 && gr == drcgra_pkg::UNITY_E7) return;
		md = (start + tp) & (hop - 1);
		soff = md != 0 ? hop - md : 0;
		nbuf = (start + tp + soff) >> k;
		span = stop - start - soff + hop - 1;
		if (span <= 0) return;
		runs = span >> k;
		if (runs <= 0) return;
		h = (lzc(gr) < lzc(gl) ? lzc(gr) : lzc(gl)) - 1;
		if (h > 8) h = 8;
		if (h < 0) h = 0;
		inc = (longint'(gr) * (64'sd1 << h) - longint'(gl) * (64'sd1 << h)) / d;
		istep = inc * hop;
		n = start + soff;
		acc = inc * n + longint'(gl) * (64'sd1 << h);
		ramp_cnt++;
		for (int i = 0; i < runs; i++) begin
			idx = nbuf + i;
			if (idx >= 0 && idx < DEPTH) begin
				g = sat32(acc);
				p = (longint'(mdl_store[idx]) * longint'(g)) >>> 32;
				mdl_store[idx] = sat32(p * (64'sd1 << (8 - h)));
			end
			acc += istep;
		end
	endfunction

	function automatic void gain_node(int nt, int ng);
		int t, tp, d, fs1, start, stop, gl, gr;
		t = wrap16(longint'(nt) + mdl_seg_off);
		tp = wrap16(longint'(mdl_ptime) + mdl_seg_off);
		d = wrap16(longint'(t) - tp);
		fs1 = int'(mdl_fsize) - 1;
		node_cnt++;
		if (d < 0) return;
		if (tp >= fs1 || t < 0) begin
			mdl_ptime = nt;
			mdl_pgain = ng;
			return;
		end
		start = -tp > 1 ? -tp : 1;
		stop = (t < fs1 ? t : fs1) - tp + 1;
		gl = scale_gain(mdl_pgain, mdl_pchan);
		if (start == 1) begin
			gr = scale_gain(ng, mdl_chan);
			mdl_pchan = mdl_chan;
		end else begin
			gr = scale_gain(ng, mdl_pchan);
		end
		apply_ramp(tp, d, start, stop, gl, gr);
		mdl_ptime = nt;
		mdl_pgain = ng;
	endfunction

	// advance the model by one accepted word; returns 1 with the read word
	function automatic bit model_item(row_t r, output int word);
		word = 0;
		case (r.op)
			drcgra_pkg::OP_WRITE: begin
				mdl_store[r.idx] = r.val;
				mdl_wr[r.idx] = 1'b1;
			end
			drcgra_pkg::OP_PREV: begin
				mdl_ptime = wrap16(r.nt);
				mdl_pgain = r.ng;
				mdl_seg_off = wrap16(r.toff);
			end
			drcgra_pkg::OP_NODE: gain_node(wrap16(r.nt), r.ng);
			drcgra_pkg::OP_READ: begin
				word = mdl_store[r.idx];
				return 1;
			end
			default: ;
		endcase
		return 0;
	endfunction

	task automatic send_word(row_t r);
		int word;
		bit st;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= r.op;
		sample_index <= r.idx[9:0];
		sample_value <= r.val;
		node_time <= r.nt[15:0];
		node_gain <= r.ng;
		time_offset <= r.toff[15:0];
		do begin
			@(negedge clk);
			st = in_stall;
			@(posedge clk);
		end while (st);
		item_cnt++;
		if (model_item(r, word)) begin
			read_cnt++;
			read_words.push_back(r.typed ? r.want : word);
		end
	endtask

	// idle the input, drain all reads, let a trailing node finish
	task automatic settle();
		in_valid <= 1'b0;
		wait (read_words.size() == 0);
		repeat (100 + 3 * int'(mdl_fsize)) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] ix, logic [31:0] data);
		bit rd;
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data <= data;
		do begin
			@(negedge clk);
			rd = cfg_ready;
			@(posedge clk);
		end while (!rd);
		cfg_valid <= 1'b0;
		case (ix)
			drcgra_pkg::CFG_FRAME_SIZE:   mdl_fsize = data[10:0];
			drcgra_pkg::CFG_STEP_LOG2:    mdl_step = data[3:0];
			drcgra_pkg::CFG_CHANNEL_GAIN: mdl_chan = data;
			default: ;
		endcase
	endtask

	function automatic row_t mk(drcgra_pkg::op_t op, int idx, int val, int nt, int ng,
		int toff, bit typed = 0, int want = 0);
		row_t r;
		r.op = op; r.idx = idx; r.val = val; r.nt = nt; r.ng = ng; r.toff = toff;
		r.typed = typed; r.want = want;
		return r;
	endfunction

	function automatic int pick_gain();
		case ($urandom_range(0, 7))
			0: return drcgra_pkg::UNITY_E7;
			1: return drcgra_pkg::UNITY_E7 + $urandom_range(0, 4000) - 2000;
			2: return $urandom;
			3: return $urandom_range(1 << 20, 1 << 27);
			4: return -$urandom_range(1, 1 << 25);
			5: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $urandom_range(drcgra_pkg::UNITY_E7 / 4, drcgra_pkg::UNITY_E7 * 3);
		endcase
	endfunction

	// mostly ordered node sequences inside the frame, with some noise
	function automatic row_t rand_row();
		int fs, sel, nt, toff, ri;
		fs = mdl_fsize > 0 ? int'(mdl_fsize) : 1;
		sel = $urandom_range(0, 99);
		if (sel < 20)
			return mk(drcgra_pkg::OP_WRITE, $urandom_range(0, DEPTH - 1), $urandom, 0, 0, 0);
		if (sel < 30) begin
			toff = $urandom_range(0, 3) == 0 ? int'($urandom) : $urandom_range(0, 2 * fs) - fs;
			nt = $urandom_range(0, 3) == 0 ? int'($urandom) : $urandom_range(0, fs) - fs / 2;
			return mk(drcgra_pkg::OP_PREV, $urandom_range(0, DEPTH - 1), $urandom, nt,
				pick_gain(), toff);
		end
		if (sel < 65) begin
			if ($urandom_range(0, 5) == 0) nt = $urandom;
			else nt = mdl_ptime + $urandom_range(0, fs / 3 + 2);
			return mk(drcgra_pkg::OP_NODE, $urandom_range(0, DEPTH - 1), $urandom, nt,
				pick_gain(), $urandom);
		end
		// reads only target entries that have been written
		do ri = $urandom_range(0, DEPTH - 1); while (!mdl_wr[ri]);
		return mk(drcgra_pkg::OP_READ, ri, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// accepted-word sampling and result check
	bit o_take;
	int o_word;
	int idle_cycles;

	always @(negedge clk) begin
		o_take = out_valid && !out_stall;
		o_word = sample_out;
		if ((in_valid && !in_stall) || o_take || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		int want;
		if (o_take) begin
			if (read_words.size() == 0) begin
				$error("sample_out: no read pending, actual %0d", o_word);
				fail_cnt++;
			end else begin
				want = read_words.pop_front();
				if (want !== o_word) begin
					$error("sample_out: expected %0d actual %0d", want, o_word);
					fail_cnt++;
				end
			end
		end
	end

	// receiver side: random stall bursts and one long hold
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int fs_set [8];
		int st_set [8];
		int cg_set [8];
		fs_set = '{1024, 16, 64, 1, 40, 200, 2047, 33};
		st_set = '{0, 0, 3, 0, 15, 8, 2, 1};
		mdl_ptime = 0; mdl_pgain = drcgra_pkg::UNITY_E7; mdl_seg_off = 0;
		mdl_pchan = drcgra_pkg::UNITY_E8;
		mdl_fsize = 1024; mdl_step = 0; mdl_chan = drcgra_pkg::UNITY_E8;
		cg_set = '{drcgra_pkg::UNITY_E8, $urandom, drcgra_pkg::UNITY_E8 * 2, 32'sh80000000,
			32'sh7FFFFFFF, drcgra_pkg::UNITY_E8, drcgra_pkg::UNITY_E8 / 2, $urandom};
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// fill the low part of the store and one high entry before any read
		for (int i = 0; i < 48; i++)
			send_word(mk(drcgra_pkg::OP_WRITE, i, $urandom, 0, 0, 0));
		send_word(mk(drcgra_pkg::OP_WRITE, 1000, $urandom, 0, 0, 0));

		// directed steps
		steps.push_back(mk(drcgra_pkg::OP_WRITE, 0, 32'sh7FFFFFFF, 0, 0, 0));
		steps.push_back(mk(drcgra_pkg::OP_READ, 0, 0, 0, 0, 0, 1, 32'sh7FFFFFFF));
		steps.push_back(mk(drcgra_pkg::OP_WRITE, 1023, 32'sh80000000, 0, 0, 0));
		steps.push_back(mk(drcgra_pkg::OP_READ, 1023, 0, 0, 0, 0, 1, 32'sh80000000));
		steps.push_back(mk(drcgra_pkg::OP_WRITE, 5, 0, 0, 0, 0));
		steps.push_back(mk(drcgra_pkg::OP_READ, 5, 0, 0, 0, 0, 1, 0));
		steps.push_back(mk(drcgra_pkg::OP_PREV, 0, 0, 0, drcgra_pkg::UNITY_E7, 0));
		// unity segment
		steps.push_back(mk(drcgra_pkg::OP_NODE, 0, 0, 10, drcgra_pkg::UNITY_E7, 0));
		// backward node
		steps.push_back(mk(drcgra_pkg::OP_NODE, 0, 0, 5, drcgra_pkg::UNITY_E7 * 2, 0));
		steps.push_back(mk(drcgra_pkg::OP_NODE, 0, 0, 20, drcgra_pkg::UNITY_E7 * 2, 0));
		// negative gain
		steps.push_back(mk(drcgra_pkg::OP_NODE, 0, 0, 30, -drcgra_pkg::UNITY_E7, 0));
		// saturating
		steps.push_back(mk(drcgra_pkg::OP_NODE, 0, 0, 40, 32'sh7FFFFFFF, 0));
		steps.push_back(mk(drcgra_pkg::OP_NODE, 0, 0, 50, 32'sh80000000, 0));
		steps.push_back(mk(drcgra_pkg::OP_READ, 15, 0, 0, 0, 0));
		steps.push_back(mk(drcgra_pkg::OP_READ, 35, 0, 0, 0, 0));
		steps.push_back(mk(drcgra_pkg::OP_READ, 45, 0, 0, 0, 0));
		// wrapped times
		steps.push_back(mk(drcgra_pkg::OP_PREV, 0, 0, 32767, drcgra_pkg::UNITY_E7, -32768));
		steps.push_back(mk(drcgra_pkg::OP_NODE, 0, 0, -32768, drcgra_pkg::UNITY_E7 / 2, 0));
		// starts before frame
		steps.push_back(mk(drcgra_pkg::OP_PREV, 0, 0, -20, drcgra_pkg::UNITY_E7 / 2, 4));
		steps.push_back(mk(drcgra_pkg::OP_NODE, 0, 0, 12, drcgra_pkg::UNITY_E7 * 3, 0));
		// beyond the frame
		steps.push_back(mk(drcgra_pkg::OP_PREV, 0, 0, 2000, drcgra_pkg::UNITY_E7, 0));
		steps.push_back(mk(drcgra_pkg::OP_NODE, 0, 0, 2100, drcgra_pkg::UNITY_E7 * 2, 0));
		steps.push_back(mk(drcgra_pkg::OP_READ, 2, 0, 0, 0, 0));
		steps.push_back(mk(drcgra_pkg::OP_READ, 1000, 0, 0, 0, 0));
		foreach (steps[i]) send_word(steps[i]);

		// configuration phases with random traffic
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			cfg_write(drcgra_pkg::CFG_FRAME_SIZE, fs_set[ph]);
			cfg_write(drcgra_pkg::CFG_STEP_LOG2, st_set[ph]);
			cfg_write(drcgra_pkg::CFG_CHANNEL_GAIN, cg_set[ph]);
			if (ph == 7) quiet = 1;
			if (ph == 2) begin
				hold_req = 1;
				for (int i = 0; i < 12; i++)
					send_word(mk(drcgra_pkg::OP_READ, i, 0, 0, 0, 0));
			end
			for (int i = 0; i < (ph == 6 ? 40 : 95); i++) begin
				if (ph == 3 && i == 50) begin
					in_valid <= 1'b0;
					wait (read_words.size() == 0);
				end
				send_word(rand_row());
			end
		end

		in_valid <= 1'b0;
		wait (read_words.size() == 0);
		repeat (100 + 3 * int'(mdl_fsize)) @(posedge clk);
		$display("tb: %0d words sent, %0d reads checked, %0d gain nodes, %0d ramps applied",
			item_cnt, read_cnt, node_cnt, ramp_cnt);
		$display("tb: 8 register settings incl. frame sizes 1 and 2047, hops 1..256");
		if (fail_cnt == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/drcgra_pkg.sv
rtl/drcgra_mul.sv
rtl/drcgra_div.sv
rtl/drc_node_gain_ramp_apply.sv
test/tb.sv
